// ----- hw/rtl/jtfe_pkg.sv -----
// Shared types, operation codes and constants for the job table EFT estimator.
`timescale 1ns / 1ps
package jtfe_pkg;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] job_id;
    logic [31:0] est_time;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_job_id;
    logic [1:0]  job_state;
    logic [31:0] out_est_time;
    logic [31:0] out_start_time;
    logic [39:0] eft;
    logic [7:0]  active_count;
    logic        last;
  } result_t;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_FINISH = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_LIST   = 3'd4;
  localparam logic [2:0] CMD_EST    = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_TBL_FULL  = 3'd2;
  localparam logic [2:0] ST_Q_FULL    = 3'd3;
  localparam logic [2:0] ST_NO_ACTIVE = 3'd4;

  localparam logic [1:0] JS_WAITING  = 2'd0;
  localparam logic [1:0] JS_RUNNING  = 2'd1;
  localparam logic [1:0] JS_FINISHED = 2'd2;

  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_SCAN      = 5'd2;
  localparam logic [4:0] OP_ADD       = 5'd3;
  localparam logic [4:0] OP_START_SET = 5'd4;
  localparam logic [4:0] OP_CMP_STEP  = 5'd5;
  localparam logic [4:0] OP_CMP_END   = 5'd6;
  localparam logic [4:0] OP_FINISH    = 5'd7;
  localparam logic [4:0] OP_DELETE    = 5'd8;
  localparam logic [4:0] OP_LIST_INIT = 5'd9;
  localparam logic [4:0] OP_LIST_STEP = 5'd10;
  localparam logic [4:0] OP_LIST_END  = 5'd11;
  localparam logic [4:0] OP_EST_INIT  = 5'd12;
  localparam logic [4:0] OP_RUN_LATCH = 5'd13;
  localparam logic [4:0] OP_EI_INC    = 5'd14;
  localparam logic [4:0] OP_VAL       = 5'd15;
  localparam logic [4:0] OP_MIN_INIT  = 5'd16;
  localparam logic [4:0] OP_MIN_STEP  = 5'd17;
  localparam logic [4:0] OP_ACCUM     = 5'd18;
  localparam logic [4:0] OP_WAIT_INIT = 5'd19;
  localparam logic [4:0] OP_WAIT_KEY  = 5'd20;
  localparam logic [4:0] OP_WAIT_HIT  = 5'd21;
  localparam logic [4:0] OP_FI_INC    = 5'd22;
  localparam logic [4:0] OP_RESP      = 5'd23;
  localparam logic [4:0] OP_RESP_EFT  = 5'd24;

  // reciprocal of ten: (x * RECIP10) >> 35 is x / 10 for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SHIFT = 35;
  localparam logic [39:0] EFT_LIMIT = 40'hFF_FFFF_FFFF;
  localparam logic [7:0]  ACTIVE_LIMIT = 8'd255;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       scan_done;
    logic       scan_hit;
    logic       table_full;
    logic       fifo_full;
    logic       ent_end;
    logic       ent_running;
    logic       fifo_end;
    logic       min_end;
    logic       list_stop;
  } dp_stat_t;

endpackage

// ----- hw/rtl/jtfe_dp.sv -----
// Datapath: job table, waiting FIFO, processor loads and result register.
`timescale 1ns / 1ps
module jtfe_dp import jtfe_pkg::*; #(
  parameter int MAX_JOBS  = 16,
  parameter int MAX_PROCS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       cfg_valid,
  input  logic [3:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output result_t    result,
  output logic       done
);

  localparam int IW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int NPW = $clog2(MAX_PROCS + 1);
  localparam int LW  = (CW > 8) ? CW : 8;

  logic [15:0] ent_id    [MAX_JOBS];
  logic [1:0]  ent_st    [MAX_JOBS];
  logic [31:0] ent_est   [MAX_JOBS];
  logic [31:0] ent_start [MAX_JOBS];
  logic [15:0] fifo      [MAX_JOBS];
  logic [39:0] proc_fin  [MAX_PROCS];

  logic [CW-1:0]  used, fcnt, ei, fi, fj, n;
  logic [7:0]     active;
  logic [3:0]     proc_count;
  item_t          cur;
  logic [15:0]    key;
  logic [NPW-1:0] p;
  logic [PW-1:0]  best;
  logic [39:0]    bestv;
  logic [33:0]    rem;
  logic [63:0]    prod;
  logic [32:0]    addv;
  logic           have_pend;
  logic [15:0]    pend_id;
  logic [1:0]     pend_st;
  logic [31:0]    pend_est, pend_start;

  logic [IW-1:0]  ei_idx, fi_idx, fj_idx, fcnt_idx;
  logic [NPW-1:0] np;
  logic           ent_end;
  logic [15:0]    cur_id;
  logic [1:0]     cur_st;
  logic [40:0]    acc_sum;
  logic           rem_pos;

  assign ei_idx   = ei[IW-1:0];
  assign fi_idx   = fi[IW-1:0];
  assign fj_idx   = fj[IW-1:0];
  assign fcnt_idx = fcnt[IW-1:0];
  assign ent_end  = (ei >= used);
  assign cur_id   = ent_id[ei_idx];
  assign cur_st   = ent_st[ei_idx];
  assign acc_sum  = {1'b0, bestv} + {8'd0, addv};
  assign rem_pos  = !rem[33] && (rem != 34'd0);

  always_comb begin
    if (proc_count == 4'd0) begin
      np = NPW'(1);
    end else if (int'(proc_count) > MAX_PROCS) begin
      np = NPW'(MAX_PROCS);
    end else begin
      np = NPW'(proc_count);
    end
  end

  always_comb begin
    stat.cmd         = cur.command;
    stat.ent_end     = ent_end;
    stat.scan_hit    = !ent_end && (cur_id == key);
    stat.scan_done   = ent_end || (cur_id >= key);
    stat.table_full  = (used >= CW'(MAX_JOBS));
    stat.fifo_full   = (fcnt >= CW'(MAX_JOBS));
    stat.ent_running = !ent_end && (cur_st == JS_RUNNING);
    stat.fifo_end    = (fi >= fcnt);
    stat.min_end     = (p >= np);
    stat.list_stop   = ent_end || (LW'(n) >= LW'(active));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      fcnt       <= '0;
      active     <= '0;
      proc_count <= 4'd1;
      done       <= 1'b0;
      have_pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        proc_count <= cfg_data;
      end
      case (cmd.op)
        OP_LOAD: begin
          cur <= item;
          key <= item.job_id;
          ei  <= '0;
        end
        OP_SCAN: begin
          if (!stat.scan_done) ei <= ei + 1'b1;
        end
        OP_ADD: begin
          for (int k = 0; k < MAX_JOBS; k++) begin
            if (k == int'(ei)) begin
              ent_id[k]    <= key;
              ent_st[k]    <= JS_WAITING;
              ent_est[k]   <= cur.est_time;
              ent_start[k] <= '0;
            end else if (!stat.scan_hit && k > int'(ei) && k > 0) begin
              ent_id[k]    <= ent_id[k-1];
              ent_st[k]    <= ent_st[k-1];
              ent_est[k]   <= ent_est[k-1];
              ent_start[k] <= ent_start[k-1];
            end
          end
          if (!stat.scan_hit) used <= used + 1'b1;
          fifo[fcnt_idx] <= key;
          fcnt <= fcnt + 1'b1;
          if (active != ACTIVE_LIMIT) active <= active + 1'b1;
        end
        OP_START_SET: begin
          ent_st[ei_idx]    <= JS_RUNNING;
          ent_start[ei_idx] <= cur.now_ms;
          fi <= '0;
          fj <= '0;
        end
        OP_CMP_STEP: begin
          if (fifo[fi_idx] != key) begin
            fifo[fj_idx] <= fifo[fi_idx];
            fj <= fj + 1'b1;
          end
          fi <= fi + 1'b1;
        end
        OP_CMP_END: fcnt <= fj;
        OP_FINISH: begin
          ent_st[ei_idx] <= JS_FINISHED;
          if (active != 8'd0) active <= active - 1'b1;
        end
        OP_DELETE: begin
          if (cur_st != JS_FINISHED && active != 8'd0) active <= active - 1'b1;
          for (int k = 0; k < MAX_JOBS - 1; k++) begin
            if (k >= int'(ei)) begin
              ent_id[k]    <= ent_id[k+1];
              ent_st[k]    <= ent_st[k+1];
              ent_est[k]   <= ent_est[k+1];
              ent_start[k] <= ent_start[k+1];
            end
          end
          used <= used - 1'b1;
        end
        OP_LIST_INIT: begin
          ei        <= '0;
          n         <= '0;
          have_pend <= 1'b0;
        end
        OP_LIST_STEP: begin
          if (cur_st == JS_WAITING || cur_st == JS_RUNNING) begin
            if (have_pend) begin
              result <= '{status: ST_OK, out_job_id: pend_id, job_state: pend_st,
                          out_est_time: pend_est, out_start_time: pend_start,
                          eft: '0, active_count: active, last: 1'b0};
              done   <= 1'b1;
            end
            have_pend  <= 1'b1;
            pend_id    <= cur_id;
            pend_st    <= cur_st;
            pend_est   <= ent_est[ei_idx];
            pend_start <= ent_start[ei_idx];
            n <= n + 1'b1;
          end
          ei <= ei + 1'b1;
        end
        OP_LIST_END: begin
          if (have_pend) begin
            result <= '{status: ST_OK, out_job_id: pend_id, job_state: pend_st,
                        out_est_time: pend_est, out_start_time: pend_start,
                        eft: '0, active_count: active, last: 1'b1};
          end else begin
            result <= '{status: ST_NO_ACTIVE, out_job_id: '0, job_state: '0,
                        out_est_time: '0, out_start_time: '0,
                        eft: '0, active_count: active, last: 1'b1};
          end
          done <= 1'b1;
        end
        OP_EST_INIT: begin
          for (int k = 0; k < MAX_PROCS; k++) begin
            if (k < int'(np)) proc_fin[k] <= '0;
          end
          ei <= '0;
        end
        OP_RUN_LATCH: begin
          rem  <= {2'b00, ent_start[ei_idx]} + {2'b00, ent_est[ei_idx]}
                  - {2'b00, cur.now_ms};
          prod <= ent_est[ei_idx] * RECIP10;
          ei   <= ei + 1'b1;
        end
        OP_EI_INC: ei <= ei + 1'b1;
        OP_VAL: begin
          if (rem_pos) addv <= rem[32:0];
          else addv <= {4'd0, prod[63:RECIP10_SHIFT]};
        end
        OP_MIN_INIT: begin
          p     <= NPW'(1);
          best  <= '0;
          bestv <= proc_fin[0];
        end
        OP_MIN_STEP: begin
          if (proc_fin[p[PW-1:0]] < bestv) begin
            best  <= p[PW-1:0];
            bestv <= proc_fin[p[PW-1:0]];
          end
          p <= p + 1'b1;
        end
        OP_ACCUM: begin
          proc_fin[best] <= acc_sum[40] ? EFT_LIMIT : acc_sum[39:0];
        end
        OP_WAIT_INIT: fi <= '0;
        OP_WAIT_KEY: begin
          key <= fifo[fi_idx];
          ei  <= '0;
        end
        OP_WAIT_HIT: begin
          addv <= {1'b0, ent_est[ei_idx]};
          fi   <= fi + 1'b1;
        end
        OP_FI_INC: fi <= fi + 1'b1;
        OP_RESP: begin
          result <= '{status: cmd.code, out_job_id: '0, job_state: '0,
                      out_est_time: '0, out_start_time: '0,
                      eft: '0, active_count: active, last: 1'b1};
          done   <= 1'b1;
        end
        OP_RESP_EFT: begin
          result <= '{status: ST_OK, out_job_id: '0, job_state: '0,
                      out_est_time: '0, out_start_time: '0,
                      eft: bestv, active_count: active, last: 1'b1};
          done   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/jtfe_ctrl.sv -----
// Controller: sequences datapath operations for each command.
`timescale 1ns / 1ps
module jtfe_ctrl import jtfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_RESP   = 4'd4;
  localparam logic [3:0] S_LIST   = 4'd5;
  localparam logic [3:0] S_RUN    = 4'd6;
  localparam logic [3:0] S_VAL    = 4'd7;
  localparam logic [3:0] S_MIN0   = 4'd8;
  localparam logic [3:0] S_MIN    = 4'd9;
  localparam logic [3:0] S_WAIT   = 4'd10;
  localparam logic [3:0] S_WSCAN  = 4'd11;

  localparam logic [1:0] PH_RUN   = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_RUN;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_ADD, CMD_START, CMD_FINISH, CMD_DELETE: state_next = S_SCAN;
          CMD_LIST: begin
            cmd.op     = OP_LIST_INIT;
            state_next = S_LIST;
          end
          CMD_EST: begin
            cmd.op     = OP_EST_INIT;
            phase_next = PH_RUN;
            state_next = S_RUN;
          end
          default: begin
            cmd.op     = OP_RESP;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (!stat.scan_done) begin
          cmd.op = OP_SCAN;
        end else if (stat.cmd == CMD_ADD) begin
          if (!stat.scan_hit && stat.table_full) begin
            cmd.op     = OP_RESP;
            cmd.code   = ST_TBL_FULL;
            state_next = S_IDLE;
          end else if (stat.fifo_full) begin
            cmd.op     = OP_RESP;
            cmd.code   = ST_Q_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.op     = OP_ADD;
            state_next = S_RESP;
          end
        end else if (!stat.scan_hit) begin
          cmd.op     = OP_RESP;
          cmd.code   = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else if (stat.cmd == CMD_START) begin
          cmd.op     = OP_START_SET;
          state_next = S_CMP;
        end else if (stat.cmd == CMD_FINISH) begin
          cmd.op     = OP_FINISH;
          state_next = S_RESP;
        end else begin
          cmd.op     = OP_DELETE;
          state_next = S_RESP;
        end
      end
      S_CMP: begin
        if (stat.fifo_end) begin
          cmd.op     = OP_CMP_END;
          state_next = S_RESP;
        end else begin
          cmd.op = OP_CMP_STEP;
        end
      end
      S_RESP: begin
        cmd.op     = OP_RESP;
        state_next = S_IDLE;
      end
      S_LIST: begin
        if (stat.list_stop) begin
          cmd.op     = OP_LIST_END;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_LIST_STEP;
        end
      end
      S_RUN: begin
        if (stat.ent_end) begin
          cmd.op     = OP_WAIT_INIT;
          phase_next = PH_WAIT;
          state_next = S_WAIT;
        end else if (stat.ent_running) begin
          cmd.op     = OP_RUN_LATCH;
          state_next = S_VAL;
        end else begin
          cmd.op = OP_EI_INC;
        end
      end
      S_VAL: begin
        cmd.op     = OP_VAL;
        state_next = S_MIN0;
      end
      S_MIN0: begin
        cmd.op     = OP_MIN_INIT;
        state_next = S_MIN;
      end
      S_MIN: begin
        if (!stat.min_end) begin
          cmd.op = OP_MIN_STEP;
        end else if (phase == PH_FINAL) begin
          cmd.op     = OP_RESP_EFT;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_ACCUM;
          state_next = (phase == PH_RUN) ? S_RUN : S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.fifo_end) begin
          phase_next = PH_FINAL;
          state_next = S_MIN0;
        end else begin
          cmd.op     = OP_WAIT_KEY;
          state_next = S_WSCAN;
        end
      end
      S_WSCAN: begin
        if (!stat.scan_done) begin
          cmd.op = OP_SCAN;
        end else if (stat.scan_hit) begin
          cmd.op     = OP_WAIT_HIT;
          state_next = S_MIN0;
        end else begin
          cmd.op     = OP_FI_INC;
          state_next = S_WAIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/job_table_fifo_eft_estimator_top.sv -----
// Top level of the job table with waiting FIFO and earliest-finish-time estimator.
// Sequencing: add/finish/delete scan the table for the id, start also compacts the FIFO,
//   list walks the table entries; estimate runs a min search over the processors in use
//   per running job and per queued id found by a table scan, then a final min search.
// Throughput: one command at a time, busy until the last result; receiver cannot stall.
// Reset (rst, synchronous): empty table and FIFO, zero active count, proc_count = 1.
`timescale 1ns / 1ps
module job_table_fifo_eft_estimator_top import jtfe_pkg::*; #(
  parameter int MAX_JOBS  = 16,
  parameter int MAX_PROCS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output logic       done,
  output result_t    result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config transfer is always taken; software is to write only while idle, not enforced here
  assign cfg_ready = 1'b1;

  // controller: one FSM walks each command through datapath operations
  jtfe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: table, FIFO, processor loads, min search and result register
  jtfe_dp #(
    .MAX_JOBS  (MAX_JOBS),
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

endmodule

// ----- hw/rtl/jtfe_checker.sv -----
// Port-level assertions for the job table EFT estimator, bound to the top level.
`timescale 1ns / 1ps
module jtfe_checker import jtfe_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // an accepted command always occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  // more list results follow a non-final one, so the block is still working
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> busy) else $error("non-final result while idle");

  // error statuses end the command
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.last) else $error("error not final");

  // only list results carry a job id
  a_list_only: assert property (@(posedge clk) disable iff (rst)
    done && result.eft != 40'd0 |-> result.out_job_id == 16'd0 && result.last)
    else $error("estimate result carries job fields");

  // reset leaves the block idle with no strobe
  a_reset: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("not idle after reset");

endmodule

bind job_table_fifo_eft_estimator_top jtfe_checker u_jtfe_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
